[rtl/elt_pkg.sv]
// Package for the expression-language tokenizer.
// Result record type, scan modes, token and error codes, keyword table.
// No dependencies.
package elt_pkg;

    localparam int MAX_LEXEME_DEF = 255;
    localparam int LINE_BITS_DEF  = 16;
    localparam int KW_TOTAL       = 9;

    localparam logic [1:0] KIND_BYTE  = 2'd0;
    localparam logic [1:0] KIND_TOKEN = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    localparam logic [1:0] ERR_UNKNOWN = 2'd0;
    localparam logic [1:0] ERR_POINT   = 2'd1;
    localparam logic [1:0] ERR_STRING  = 2'd2;
    localparam logic [1:0] ERR_BANG    = 2'd3;

    localparam logic [4:0] TT_PLUS   = 5'd0;
    localparam logic [4:0] TT_MINUS  = 5'd1;
    localparam logic [4:0] TT_STAR   = 5'd2;
    localparam logic [4:0] TT_SLASH  = 5'd3;
    localparam logic [4:0] TT_LPAREN = 5'd4;
    localparam logic [4:0] TT_RPAREN = 5'd5;
    localparam logic [4:0] TT_SEMI   = 5'd6;
    localparam logic [4:0] TT_EQ     = 5'd7;
    localparam logic [4:0] TT_EQEQ   = 5'd8;
    localparam logic [4:0] TT_MOD    = 5'd9;
    localparam logic [4:0] TT_LT     = 5'd10;
    localparam logic [4:0] TT_LTE    = 5'd11;
    localparam logic [4:0] TT_GT     = 5'd12;
    localparam logic [4:0] TT_GTE    = 5'd13;
    localparam logic [4:0] TT_NE     = 5'd14;
    localparam logic [4:0] TT_LBRACE = 5'd15;
    localparam logic [4:0] TT_RBRACE = 5'd16;
    localparam logic [4:0] TT_STRING = 5'd17;
    localparam logic [4:0] TT_NUMBER = 5'd18;
    localparam logic [4:0] TT_IDENT  = 5'd19;
    localparam logic [4:0] TT_KW0    = 5'd20;
    localparam logic [4:0] TT_END    = 5'd29;

    typedef enum logic [11:0] {
        M_IDLE  = 12'b0000_0000_0001,
        M_NUM   = 12'b0000_0000_0010,
        M_IDENT = 12'b0000_0000_0100,
        M_STR   = 12'b0000_0000_1000,
        M_ESC   = 12'b0000_0001_0000,
        M_CMT   = 12'b0000_0010_0000,
        M_EQ    = 12'b0000_0100_0000,
        M_LT    = 12'b0000_1000_0000,
        M_GT    = 12'b0001_0000_0000,
        M_BANG  = 12'b0010_0000_0000,
        M_SLASH = 12'b0100_0000_0000,
        M_HALT  = 12'b1000_0000_0000
    } scan_mode_t;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [7:0]  lexeme_byte;
        logic [4:0]  token_type;
        logic [15:0] token_line;
        logic [7:0]  token_length;
        logic [1:0]  error_code;
        logic        last_result;
    } result_t;

    function automatic logic [2:0] kw_len(input logic [3:0] idx);
        case (idx)
            4'd0: kw_len = 3'd5;
            4'd1: kw_len = 3'd3;
            4'd2: kw_len = 3'd2;
            4'd3: kw_len = 3'd3;
            4'd4: kw_len = 3'd3;
            4'd5: kw_len = 3'd2;
            4'd6: kw_len = 3'd4;
            4'd7: kw_len = 3'd5;
            4'd8: kw_len = 3'd2;
            default: kw_len = 3'd0;
        endcase
    endfunction

    function automatic logic [7:0] kw_char(input logic [3:0] idx, input logic [2:0] pos);
        logic [39:0] txt;
        txt = 40'd0;
        case (idx)
            4'd0: txt = "print";
            4'd1: txt = {16'd0, "let"};
            4'd2: txt = {24'd0, "or"};
            4'd3: txt = {16'd0, "and"};
            4'd4: txt = {16'd0, "not"};
            4'd5: txt = {24'd0, "if"};
            4'd6: txt = {8'd0, "else"};
            4'd7: txt = "while";
            4'd8: txt = {24'd0, "do"};
            default: txt = 40'd0;
        endcase
        if (pos < kw_len(idx))
            kw_char = txt[8*(32'(kw_len(idx)) - 1 - 32'(pos)) +: 8];
        else
            kw_char = 8'd0;
    endfunction

endpackage

[rtl/elt_if.sv]
// Stream interfaces of the tokenizer: source characters in, results out.
// No dependencies.
interface elt_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;
    logic       end_of_input;

    modport source (output valid, output char_in, output end_of_input, input ready);
    modport sink (input valid, input char_in, input end_of_input, output ready);
endinterface

interface elt_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_kind;
    logic [7:0]  lexeme_byte;
    logic [4:0]  token_type;
    logic [15:0] token_line;
    logic [7:0]  token_length;
    logic [1:0]  error_code;
    logic        last_result;

    modport source (output valid, output result_kind, output lexeme_byte, output token_type,
                    output token_line, output token_length, output error_code,
                    output last_result, input ready);
    modport sink (input valid, input result_kind, input lexeme_byte, input token_type,
                  input token_line, input token_length, input error_code,
                  input last_result, output ready);
endinterface

[rtl/elt_scan.sv]
// Scanner core: mode state registers and the per-character next-state logic.
// Produces up to two result records per accepted transaction. Depends on elt_pkg.
module elt_scan #(
    parameter int MAX_LEXEME = elt_pkg::MAX_LEXEME_DEF,
    parameter int LINE_BITS  = elt_pkg::LINE_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             fire,
    input  logic [7:0]       char_in,
    input  logic             end_of_input,
    output logic [1:0]       push_count,
    output elt_pkg::result_t res0,
    output elt_pkg::result_t res1
);
    localparam int CW = $clog2(MAX_LEXEME + 1);
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_LEXEME);
    localparam logic [LINE_BITS-1:0] LINE_MAX = {LINE_BITS{1'b1}};

    elt_pkg::scan_mode_t mode_reg, mode_next;
    logic [LINE_BITS-1:0] line_reg, line_next;
    logic [LINE_BITS-1:0] tsl_reg, tsl_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic                 point_reg, point_next;
    logic                 dq_reg, dq_next;
    logic [8:0]           kw_reg, kw_next;

    elt_pkg::result_t a, b;
    logic a_v, b_v, run_idle;
    logic [7:0] c;

    function automatic logic [15:0] clip_line(input logic [LINE_BITS-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        clip_line = (w > 32'hFFFF) ? 16'hFFFF : w[15:0];
    endfunction

    function automatic elt_pkg::result_t mk_tok(input logic [4:0] t,
                                                input logic [LINE_BITS-1:0] ln,
                                                input logic [CW-1:0] len);
        elt_pkg::result_t r;
        logic [31:0] w;
        w = 32'(len);
        r = '0;
        r.result_kind  = elt_pkg::KIND_TOKEN;
        r.token_type   = t;
        r.token_line   = clip_line(ln);
        r.token_length = (w > 32'd255) ? 8'hFF : w[7:0];
        mk_tok = r;
    endfunction

    function automatic elt_pkg::result_t mk_err(input logic [1:0] code,
                                                input logic [LINE_BITS-1:0] ln);
        elt_pkg::result_t r;
        r = '0;
        r.result_kind = elt_pkg::KIND_ERROR;
        r.token_line  = clip_line(ln);
        r.error_code  = code;
        mk_err = r;
    endfunction

    function automatic elt_pkg::result_t mk_byte(input logic [7:0] v);
        elt_pkg::result_t r;
        r = '0;
        r.result_kind = elt_pkg::KIND_BYTE;
        r.lexeme_byte = v;
        mk_byte = r;
    endfunction

    function automatic logic [8:0] kw_upd(input logic [8:0] hits, input logic [CW-1:0] cnt,
                                          input logic [7:0] ch);
        logic [8:0] h;
        logic [31:0] w;
        h = hits;
        w = 32'(cnt);
        for (int i = 0; i < elt_pkg::KW_TOTAL; i++) begin
            if (w >= 32'(elt_pkg::kw_len(4'(i)))
                || elt_pkg::kw_char(4'(i), w[2:0]) != ch)
                h[i] = 1'b0;
        end
        kw_upd = h;
    endfunction

    function automatic logic [4:0] ident_type(input logic [8:0] hits, input logic [CW-1:0] cnt);
        logic [4:0] t;
        logic found;
        t = elt_pkg::TT_IDENT;
        found = 1'b0;
        for (int i = 0; i < elt_pkg::KW_TOTAL; i++) begin
            if (!found && hits[i] && 32'(cnt) == 32'(elt_pkg::kw_len(4'(i)))) begin
                t = elt_pkg::TT_KW0 + 5'(i);
                found = 1'b1;
            end
        end
        ident_type = t;
    endfunction

    function automatic logic is_digit(input logic [7:0] ch);
        is_digit = ch >= "0" && ch <= "9";
    endfunction

    function automatic logic is_alpha(input logic [7:0] ch);
        is_alpha = ch == "_" || (ch >= "a" && ch <= "z") || (ch >= "A" && ch <= "Z");
    endfunction

    function automatic logic [CW-1:0] inc_cnt(input logic [CW-1:0] v);
        inc_cnt = (v < CNT_MAX) ? v + CW'(1) : v;
    endfunction

    always_comb
    begin
        mode_next  = mode_reg;
        line_next  = line_reg;
        tsl_next   = tsl_reg;
        cnt_next   = cnt_reg;
        point_next = point_reg;
        dq_next    = dq_reg;
        kw_next    = kw_reg;
        a = '0;
        b = '0;
        a_v = 1'b0;
        b_v = 1'b0;
        run_idle = 1'b0;
        c = char_in;

        if (mode_reg == elt_pkg::M_HALT) begin
        end else if (end_of_input) begin
            case (mode_reg)
                elt_pkg::M_NUM:
                begin
                    a = mk_tok(elt_pkg::TT_NUMBER, tsl_reg, cnt_reg);
                    a_v = 1'b1;
                end
                elt_pkg::M_IDENT:
                begin
                    a = mk_tok(ident_type(kw_reg, cnt_reg), tsl_reg, cnt_reg);
                    a_v = 1'b1;
                end
                elt_pkg::M_STR, elt_pkg::M_ESC:
                begin
                    a = mk_err(elt_pkg::ERR_STRING, line_reg);
                    a_v = 1'b1;
                end
                elt_pkg::M_BANG:
                begin
                    a = mk_err(elt_pkg::ERR_BANG, line_reg);
                    a_v = 1'b1;
                end
                elt_pkg::M_EQ:
                begin
                    a = mk_tok(elt_pkg::TT_EQ, line_reg, CW'(1));
                    a_v = 1'b1;
                end
                elt_pkg::M_LT:
                begin
                    a = mk_tok(elt_pkg::TT_LT, line_reg, CW'(1));
                    a_v = 1'b1;
                end
                elt_pkg::M_GT:
                begin
                    a = mk_tok(elt_pkg::TT_GT, line_reg, CW'(1));
                    a_v = 1'b1;
                end
                elt_pkg::M_SLASH:
                begin
                    a = mk_tok(elt_pkg::TT_SLASH, line_reg, CW'(1));
                    a_v = 1'b1;
                end
                default:
                begin
                end
            endcase
            mode_next = elt_pkg::M_HALT;
            if (!(mode_reg == elt_pkg::M_STR || mode_reg == elt_pkg::M_ESC
                  || mode_reg == elt_pkg::M_BANG)) begin
                tsl_next = line_reg;
                b = mk_tok(elt_pkg::TT_END, line_reg, CW'(0));
                b_v = 1'b1;
            end
        end else begin
            case (mode_reg)
                elt_pkg::M_NUM:
                begin
                    if (is_digit(c)) begin
                        a = mk_byte(c);
                        a_v = 1'b1;
                        cnt_next = inc_cnt(cnt_reg);
                    end else if (c == ".") begin
                        a_v = 1'b1;
                        if (point_reg) begin
                            a = mk_err(elt_pkg::ERR_POINT, line_reg);
                            mode_next = elt_pkg::M_HALT;
                        end else begin
                            point_next = 1'b1;
                            a = mk_byte(c);
                            cnt_next = inc_cnt(cnt_reg);
                        end
                    end else begin
                        a = mk_tok(elt_pkg::TT_NUMBER, tsl_reg, cnt_reg);
                        a_v = 1'b1;
                        run_idle = 1'b1;
                    end
                end
                elt_pkg::M_IDENT:
                begin
                    a_v = 1'b1;
                    if (is_alpha(c) || is_digit(c)) begin
                        kw_next = kw_upd(kw_reg, cnt_reg, c);
                        a = mk_byte(c);
                        cnt_next = inc_cnt(cnt_reg);
                    end else begin
                        a = mk_tok(ident_type(kw_reg, cnt_reg), tsl_reg, cnt_reg);
                        run_idle = 1'b1;
                    end
                end
                elt_pkg::M_STR:
                begin
                    a_v = 1'b1;
                    if (c == (dq_reg ? 8'h22 : 8'h27)) begin
                        a = mk_tok(elt_pkg::TT_STRING, tsl_reg, cnt_reg);
                        mode_next = elt_pkg::M_IDLE;
                    end else if (c == 8'h0A) begin
                        a = mk_err(elt_pkg::ERR_STRING, line_reg);
                        mode_next = elt_pkg::M_HALT;
                    end else if (c == 8'h5C) begin
                        a_v = 1'b0;
                        mode_next = elt_pkg::M_ESC;
                    end else begin
                        a = mk_byte(c);
                        cnt_next = inc_cnt(cnt_reg);
                    end
                end
                elt_pkg::M_ESC:
                begin
                    if (c == 8'h0A && line_reg != LINE_MAX)
                        line_next = line_reg + LINE_BITS'(1);
                    case (c)
                        "b": a = mk_byte(8'd8);
                        "t": a = mk_byte(8'd9);
                        "n": a = mk_byte(8'd10);
                        "f": a = mk_byte(8'd12);
                        "r": a = mk_byte(8'd13);
                        default: a = mk_byte(c);
                    endcase
                    a_v = 1'b1;
                    cnt_next = inc_cnt(cnt_reg);
                    mode_next = elt_pkg::M_STR;
                end
                elt_pkg::M_CMT:
                begin
                    run_idle = (c == 8'h0A);
                end
                elt_pkg::M_EQ, elt_pkg::M_LT, elt_pkg::M_GT:
                begin
                    a_v = 1'b1;
                    tsl_next = line_reg;
                    mode_next = elt_pkg::M_IDLE;
                    if (c == "=") begin
                        a = mk_tok(mode_reg == elt_pkg::M_EQ ? elt_pkg::TT_EQEQ :
                                   mode_reg == elt_pkg::M_LT ? elt_pkg::TT_LTE :
                                   elt_pkg::TT_GTE, line_reg, CW'(2));
                    end else begin
                        a = mk_tok(mode_reg == elt_pkg::M_EQ ? elt_pkg::TT_EQ :
                                   mode_reg == elt_pkg::M_LT ? elt_pkg::TT_LT :
                                   elt_pkg::TT_GT, line_reg, CW'(1));
                        run_idle = 1'b1;
                    end
                end
                elt_pkg::M_SLASH:
                begin
                    if (c == "/") begin
                        mode_next = elt_pkg::M_CMT;
                    end else begin
                        a = mk_tok(elt_pkg::TT_SLASH, line_reg, CW'(1));
                        a_v = 1'b1;
                        tsl_next = line_reg;
                        run_idle = 1'b1;
                    end
                end
                elt_pkg::M_BANG:
                begin
                    a_v = 1'b1;
                    if (c == "=") begin
                        mode_next = elt_pkg::M_IDLE;
                        tsl_next = line_reg;
                        a = mk_tok(elt_pkg::TT_NE, line_reg, CW'(2));
                    end else begin
                        a = mk_err(elt_pkg::ERR_BANG, line_reg);
                        mode_next = elt_pkg::M_HALT;
                    end
                end
                default:
                begin
                    run_idle = 1'b1;
                end
            endcase

            if (run_idle) begin
                mode_next = elt_pkg::M_IDLE;
                b_v = 1'b1;
                case (c)
                    "+": b = mk_tok(elt_pkg::TT_PLUS, line_reg, CW'(1));
                    "-": b = mk_tok(elt_pkg::TT_MINUS, line_reg, CW'(1));
                    "*": b = mk_tok(elt_pkg::TT_STAR, line_reg, CW'(1));
                    "(": b = mk_tok(elt_pkg::TT_LPAREN, line_reg, CW'(1));
                    ")": b = mk_tok(elt_pkg::TT_RPAREN, line_reg, CW'(1));
                    ";": b = mk_tok(elt_pkg::TT_SEMI, line_reg, CW'(1));
                    "%": b = mk_tok(elt_pkg::TT_MOD, line_reg, CW'(1));
                    "{": b = mk_tok(elt_pkg::TT_LBRACE, line_reg, CW'(1));
                    "}": b = mk_tok(elt_pkg::TT_RBRACE, line_reg, CW'(1));
                    default: b_v = 1'b0;
                endcase
                if (b_v)
                    tsl_next = line_reg;
                case (c)
                    "/": mode_next = elt_pkg::M_SLASH;
                    "=": mode_next = elt_pkg::M_EQ;
                    "<": mode_next = elt_pkg::M_LT;
                    ">": mode_next = elt_pkg::M_GT;
                    "!": mode_next = elt_pkg::M_BANG;
                    8'h22, 8'h27:
                    begin
                        tsl_next = line_reg;
                        cnt_next = '0;
                        point_next = 1'b0;
                        kw_next = '1;
                        dq_next = (c == 8'h22);
                        mode_next = elt_pkg::M_STR;
                    end
                    8'h0A:
                    begin
                        if (line_reg != LINE_MAX)
                            line_next = line_reg + LINE_BITS'(1);
                    end
                    8'h20, 8'h09, 8'h0D:
                    begin
                    end
                    default:
                    begin
                        if (!b_v) begin
                            b_v = 1'b1;
                            if (is_digit(c) || is_alpha(c)) begin
                                tsl_next = line_reg;
                                cnt_next = CW'(1);
                                point_next = 1'b0;
                                kw_next = is_alpha(c) ? kw_upd(9'h1FF, CW'(0), c) : 9'h1FF;
                                mode_next = is_digit(c) ? elt_pkg::M_NUM : elt_pkg::M_IDENT;
                                b = mk_byte(c);
                            end else begin
                                b = mk_err(elt_pkg::ERR_UNKNOWN, line_reg);
                                mode_next = elt_pkg::M_HALT;
                            end
                        end
                    end
                endcase
            end
        end

        if (b_v)
            b.last_result = 1'b1;
        else if (a_v)
            a.last_result = 1'b1;
    end

    always_comb
    begin
        if (!fire)
            push_count = 2'd0;
        else
            push_count = 2'(a_v) + 2'(b_v);
        res0 = a_v ? a : b;
        res1 = b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg  <= elt_pkg::M_IDLE;
            line_reg  <= LINE_BITS'(1);
            tsl_reg   <= LINE_BITS'(1);
            cnt_reg   <= '0;
            point_reg <= 1'b0;
            dq_reg    <= 1'b0;
            kw_reg    <= '1;
        end else if (fire) begin
            mode_reg  <= mode_next;
            line_reg  <= line_next;
            tsl_reg   <= tsl_next;
            cnt_reg   <= cnt_next;
            point_reg <= point_next;
            dq_reg    <= dq_next;
            kw_reg    <= kw_next;
        end
    end

endmodule

[rtl/elt_fifo.sv]
// Four-entry result queue, takes up to two per cycle, pops one if ready.
// Depends on elt_pkg.
module elt_fifo (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [1:0]       push_count,
    input  elt_pkg::result_t d0,
    input  elt_pkg::result_t d1,
    output logic             has_room,
    output logic             out_valid,
    input  logic             out_ready,
    output elt_pkg::result_t out_data
);
    elt_pkg::result_t mem_reg [4];
    logic [1:0] wr_reg, rd_reg;
    logic [2:0] cnt_reg, cnt_next;
    logic pop;

    assign pop       = out_valid && out_ready;
    assign out_valid = cnt_reg != 3'd0;
    assign has_room  = cnt_reg <= 3'd2;
    assign out_data  = mem_reg[rd_reg];
    assign cnt_next  = cnt_reg + 3'(push_count) - 3'(pop);

    always_ff @(posedge clk)
    begin
        if (push_count != 2'd0)
            mem_reg[wr_reg] <= d0;
        if (push_count == 2'd2)
            mem_reg[wr_reg + 2'd1] <= d1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_reg + push_count;
            rd_reg  <= rd_reg + 2'(pop);
            cnt_reg <= cnt_next;
        end
    end

endmodule

[rtl/expression_language_tokenizer_unit.sv]
// Top level of the expression-language tokenizer.
// Depends on elt_pkg, elt_if, elt_scan and elt_fifo.
//
// One source character (or the end-of-input mark) is taken per cycle while
// the queue has room; each transaction updates the scan mode and emits zero,
// one or two results (lexeme bytes, tokens, errors) into a four-entry queue,
// which drains one result per cycle while the output side is ready. Input is
// held off while fewer than two queue slots are free. After an error or the
// end token the block accepts input but emits nothing until reset.
module expression_language_tokenizer_unit #(
    parameter int MAX_LEXEME = elt_pkg::MAX_LEXEME_DEF,
    parameter int LINE_BITS  = elt_pkg::LINE_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    elt_char_if.sink      chars,
    elt_result_if.source  results
);
    logic             fire;
    logic             has_room;
    logic [1:0]       push_count;
    elt_pkg::result_t res0, res1, head;

    assign chars.ready = has_room;
    assign fire = chars.valid && has_room;

    elt_scan #(
        .MAX_LEXEME (MAX_LEXEME),
        .LINE_BITS  (LINE_BITS)
    ) u_scan (
        .clk          (clk),
        .rst_n        (rst_n),
        .fire         (fire),
        .char_in      (chars.char_in),
        .end_of_input (chars.end_of_input),
        .push_count   (push_count),
        .res0         (res0),
        .res1         (res1)
    );

    elt_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_count (push_count),
        .d0         (res0),
        .d1         (res1),
        .has_room   (has_room),
        .out_valid  (results.valid),
        .out_ready  (results.ready),
        .out_data   (head)
    );

    assign results.result_kind  = head.result_kind;
    assign results.lexeme_byte  = head.lexeme_byte;
    assign results.token_type   = head.token_type;
    assign results.token_line   = head.token_line;
    assign results.token_length = head.token_length;
    assign results.error_code   = head.error_code;
    assign results.last_result  = head.last_result;

endmodule
